// File: hdl/hstw_pkg.sv
// ----------------------------------------------------------------------------
// hstw_pkg
// Shared types, codes and helper functions for the two-wire sensor reader.
// ----------------------------------------------------------------------------
package hstw_pkg;

    localparam logic [2:0] MODE_TEMP      = 3'd0;
    localparam logic [2:0] MODE_HUMID     = 3'd1;
    localparam logic [2:0] MODE_STATUS    = 3'd2;
    localparam logic [2:0] MODE_SOFT_RST  = 3'd3;
    localparam logic [2:0] MODE_IFACE_RST = 3'd4;

    localparam logic [1:0] OUTCOME_OK      = 2'd0;
    localparam logic [1:0] OUTCOME_NO_ACK  = 2'd1;
    localparam logic [1:0] OUTCOME_CRC_ERR = 2'd2;
    localparam logic [1:0] OUTCOME_TIMEOUT = 2'd3;

    localparam logic [2:0] REG_HALF_PERIOD = 3'd0;
    localparam logic [2:0] REG_WAIT_LIMIT  = 3'd1;
    localparam logic [2:0] REG_TEMP_CMD    = 3'd2;
    localparam logic [2:0] REG_HUMID_CMD   = 3'd3;
    localparam logic [2:0] REG_STATUS_CMD  = 3'd4;
    localparam logic [2:0] REG_SOFT_CMD    = 3'd5;

    localparam logic [7:0]  CRC_POLY     = 8'h31;
    localparam logic [3:0]  RESET_CLOCKS = 4'd9;
    localparam logic [23:0] WAIT_MAX     = 24'hFF_FFFF;

    typedef struct packed {
        logic [15:0] half_period;
        logic [23:0] wait_limit;
        logic [7:0]  temperature_command;
        logic [7:0]  humidity_command;
        logic [7:0]  status_command;
        logic [7:0]  soft_reset_command;
    } cfg_t;

    typedef struct packed {
        logic       start_req;
        logic [2:0] mode;
        logic       dat_in;
    } item_t;

    typedef struct packed {
        logic        sck;
        logic        dat_pull_low;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  outcome;
        logic [15:0] reading;
    } result_t;

    // CRC-8, polynomial 0x31, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] d;
        crc = crc_in;
        d   = data_in;
        for (int i = 0; i < 8; i++) begin
            if (crc[7] ^ d[7])
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[6:0], 1'b0};
            d = {d[6:0], 1'b0};
        end
        return crc;
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[7 - i] = v[i];
        return r;
    endfunction

endpackage

// File: hdl/humidity_sensor_two_wire_reader.sv
// ----------------------------------------------------------------------------
// humidity_sensor_two_wire_reader
// Tick-driven master for a two-wire humidity/temperature sensor.
// A tick is held in the input register; when it is processed, the sequencer
// update for it is loaded into the result register.
// Throughput: one tick per cycle, limited only by the output handshake.
// Reset: rst_n clears the sequencer to idle and the registers to their
// defaults (half period 50, no wait limit, commands 3, 5, 7 and 30).
// ----------------------------------------------------------------------------
module humidity_sensor_two_wire_reader
    import hstw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_req, [3:1] mode, [4] dat_in

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] sck, [1] dat_pull_low, [2] busy_res, [3] done_res,
    // [5:4] outcome, [21:6] reading
    output logic [23:0] m_tdata,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.half_period         <= 16'd50;
            cfg_reg.wait_limit          <= 24'd0;
            cfg_reg.temperature_command <= 8'd3;
            cfg_reg.humidity_command    <= 8'd5;
            cfg_reg.status_command      <= 8'd7;
            cfg_reg.soft_reset_command  <= 8'd30;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_HALF_PERIOD: cfg_reg.half_period         <= cfg_data[15:0];
                REG_WAIT_LIMIT:  cfg_reg.wait_limit          <= cfg_data;
                REG_TEMP_CMD:    cfg_reg.temperature_command <= cfg_data[7:0];
                REG_HUMID_CMD:   cfg_reg.humidity_command    <= cfg_data[7:0];
                REG_STATUS_CMD:  cfg_reg.status_command      <= cfg_data[7:0];
                REG_SOFT_CMD:    cfg_reg.soft_reset_command  <= cfg_data[7:0];
                default:         cfg_reg.half_period         <= cfg_reg.half_period;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            item_reg.start_req <= s_tdata[0];
            item_reg.mode      <= s_tdata[3:1];
            item_reg.dat_in    <= s_tdata[4];
        end
    end

    hstw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.reading, out_reg.outcome, out_reg.done_res,
                       out_reg.busy_res, out_reg.dat_pull_low, out_reg.sck};

    a_hold_stalled_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result overwritten while stalled");

    a_advance_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed tick produced no result");

    a_input_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending tick dropped");

endmodule

// File: hdl/hstw_ctrl.sv
// ----------------------------------------------------------------------------
// hstw_ctrl
// Sequencer for the two-wire sensor: holds the transaction state and computes
// pin levels and status for one timebase tick per step.
// ----------------------------------------------------------------------------
module hstw_ctrl
    import hstw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_IFR_HI = 5'd1;
    localparam logic [4:0] PH_IFR_LO = 5'd2;
    localparam logic [4:0] PH_TS0    = 5'd3;
    localparam logic [4:0] PH_TS1    = 5'd4;
    localparam logic [4:0] PH_TS2    = 5'd5;
    localparam logic [4:0] PH_TS3    = 5'd6;
    localparam logic [4:0] PH_TS4    = 5'd7;
    localparam logic [4:0] PH_TS5    = 5'd8;
    localparam logic [4:0] PH_CMD_LO = 5'd9;
    localparam logic [4:0] PH_CMD_HI = 5'd10;
    localparam logic [4:0] PH_ACK_LO = 5'd11;
    localparam logic [4:0] PH_ACK_HI = 5'd12;
    localparam logic [4:0] PH_WAIT   = 5'd13;
    localparam logic [4:0] PH_RD_LO  = 5'd14;
    localparam logic [4:0] PH_RD_HI  = 5'd15;
    localparam logic [4:0] PH_RA_LO  = 5'd16;
    localparam logic [4:0] PH_RA_HI  = 5'd17;

    logic [4:0]  phase_reg,       phase_next;
    logic [15:0] phase_ticks_reg, phase_ticks_next;
    logic [3:0]  bit_count_reg,   bit_count_next;
    logic [7:0]  shift_byte_reg,  shift_byte_next;
    logic [1:0]  byte_index_reg,  byte_index_next;
    logic [7:0]  crc_reg,         crc_next;
    logic [15:0] held_value_reg,  held_value_next;
    logic [2:0]  active_mode_reg, active_mode_next;
    logic [23:0] wait_ticks_reg,  wait_ticks_next;

    logic [15:0] ticks_inc;
    logic [3:0]  bit_inc;
    logic [23:0] wait_inc;
    logic [7:0]  cmd_sel;
    logic [7:0]  crc_cmd;
    logic [7:0]  crc_data;
    logic        more;
    result_t     res_c;

    assign ticks_inc = phase_ticks_reg + 16'd1;
    assign bit_inc   = bit_count_reg + 4'd1;
    assign crc_cmd   = crc8_byte(8'h00, cmd_sel);
    assign crc_data  = crc8_byte(crc_reg, shift_byte_reg);

    always_comb
    begin
        case (item.mode)
            MODE_TEMP:   cmd_sel = cfg.temperature_command;
            MODE_HUMID:  cmd_sel = cfg.humidity_command;
            MODE_STATUS: cmd_sel = cfg.status_command;
            default:     cmd_sel = cfg.soft_reset_command;
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        bit_count_next   = bit_count_reg;
        shift_byte_next  = shift_byte_reg;
        byte_index_next  = byte_index_reg;
        crc_next         = crc_reg;
        held_value_next  = held_value_reg;
        active_mode_next = active_mode_reg;
        wait_ticks_next  = wait_ticks_reg;
        wait_inc         = (wait_ticks_reg < WAIT_MAX) ? wait_ticks_reg + 24'd1
                                                       : wait_ticks_reg;
        res_c            = '0;

        if (phase_reg == PH_IDLE) begin
            if (item.start_req && item.mode <= MODE_IFACE_RST) begin
                active_mode_next = item.mode;
                bit_count_next   = '0;
                byte_index_next  = '0;
                held_value_next  = '0;
                wait_ticks_next  = '0;
                phase_ticks_next = '0;
                if (item.mode == MODE_IFACE_RST) begin
                    phase_next = PH_IFR_HI;
                end
                else begin
                    shift_byte_next = cmd_sel;
                    crc_next        = crc_cmd;
                    phase_next      = PH_TS0;
                end
            end
        end
        else if (phase_reg == PH_WAIT) begin
            if (!item.dat_in) begin
                bit_count_next   = '0;
                phase_next       = PH_RD_LO;
                phase_ticks_next = '0;
            end
            else begin
                wait_ticks_next = wait_inc;
                if (cfg.wait_limit != '0 && wait_inc >= cfg.wait_limit) begin
                    phase_next       = PH_IDLE;
                    phase_ticks_next = '0;
                    res_c.done_res   = 1'b1;
                    res_c.outcome    = OUTCOME_TIMEOUT;
                end
            end
        end
        else begin
            phase_ticks_next = ticks_inc;
            if (ticks_inc >= cfg.half_period) begin
                phase_ticks_next = '0;
                unique case (phase_reg)
                    PH_IFR_HI: phase_next = PH_IFR_LO;
                    PH_IFR_LO:
                    begin
                        if (bit_inc >= RESET_CLOCKS) begin
                            bit_count_next = '0;
                            phase_next     = PH_TS0;
                        end
                        else begin
                            bit_count_next = bit_inc;
                            phase_next     = PH_IFR_HI;
                        end
                    end
                    PH_TS0: phase_next = PH_TS1;
                    PH_TS1: phase_next = PH_TS2;
                    PH_TS2: phase_next = PH_TS3;
                    PH_TS3: phase_next = PH_TS4;
                    PH_TS4: phase_next = PH_TS5;
                    PH_TS5:
                    begin
                        if (active_mode_reg == MODE_IFACE_RST) begin
                            phase_next     = PH_IDLE;
                            res_c.done_res = 1'b1;
                        end
                        else begin
                            bit_count_next = '0;
                            phase_next     = PH_CMD_LO;
                        end
                    end
                    PH_CMD_LO: phase_next = PH_CMD_HI;
                    PH_CMD_HI:
                    begin
                        shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                        bit_count_next  = bit_inc;
                        phase_next      = (bit_inc >= 4'd8) ? PH_ACK_LO : PH_CMD_LO;
                    end
                    PH_ACK_LO: phase_next = PH_ACK_HI;
                    PH_ACK_HI:
                    begin
                        if (item.dat_in) begin
                            phase_next     = PH_IDLE;
                            res_c.done_res = 1'b1;
                            res_c.outcome  = OUTCOME_NO_ACK;
                        end
                        else if (active_mode_reg == MODE_SOFT_RST) begin
                            phase_next     = PH_IDLE;
                            res_c.done_res = 1'b1;
                        end
                        else begin
                            wait_ticks_next = '0;
                            phase_next      = PH_WAIT;
                        end
                    end
                    PH_RD_LO: phase_next = PH_RD_HI;
                    PH_RD_HI:
                    begin
                        shift_byte_next = {shift_byte_reg[6:0], item.dat_in};
                        bit_count_next  = bit_inc;
                        phase_next      = (bit_inc >= 4'd8) ? PH_RA_LO : PH_RD_LO;
                    end
                    PH_RA_LO: phase_next = PH_RA_HI;
                    PH_RA_HI:
                    begin
                        bit_count_next = '0;
                        if (active_mode_reg == MODE_STATUS) begin
                            phase_next     = PH_IDLE;
                            res_c.done_res = 1'b1;
                            res_c.reading  = {8'h00, shift_byte_reg};
                        end
                        else if (byte_index_reg == 2'd0) begin
                            held_value_next = {shift_byte_reg, 8'h00};
                            crc_next        = crc_data;
                            byte_index_next = 2'd1;
                            phase_next      = PH_RD_LO;
                        end
                        else if (byte_index_reg == 2'd1) begin
                            held_value_next = {held_value_reg[15:8], shift_byte_reg};
                            crc_next        = crc_data;
                            byte_index_next = 2'd2;
                            phase_next      = PH_RD_LO;
                        end
                        else begin
                            phase_next     = PH_IDLE;
                            res_c.done_res = 1'b1;
                            if (reverse8(shift_byte_reg) == crc_reg)
                                res_c.reading = held_value_reg;
                            else
                                res_c.outcome = OUTCOME_CRC_ERR;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end

        // pin levels follow the updated state
        more = (active_mode_next < MODE_STATUS) && (byte_index_next < 2'd2);
        unique case (phase_next) inside
            PH_IFR_HI, PH_TS0, PH_TS4, PH_ACK_HI, PH_RD_HI:
                res_c.sck = 1'b1;
            PH_TS1, PH_TS3:
            begin
                res_c.sck          = 1'b1;
                res_c.dat_pull_low = 1'b1;
            end
            PH_TS2: res_c.dat_pull_low = 1'b1;
            PH_CMD_LO: res_c.dat_pull_low = ~shift_byte_next[7];
            PH_CMD_HI:
            begin
                res_c.sck          = 1'b1;
                res_c.dat_pull_low = ~shift_byte_next[7];
            end
            PH_RA_LO: res_c.dat_pull_low = more;
            PH_RA_HI:
            begin
                res_c.sck          = 1'b1;
                res_c.dat_pull_low = more;
            end
            default: res_c.sck = 1'b0;
        endcase
        res_c.busy_res = (phase_next != PH_IDLE);
    end

    assign res = res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= '0;
            bit_count_reg   <= '0;
            shift_byte_reg  <= '0;
            byte_index_reg  <= '0;
            crc_reg         <= '0;
            held_value_reg  <= '0;
            active_mode_reg <= '0;
            wait_ticks_reg  <= '0;
        end
        else if (step) begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            bit_count_reg   <= bit_count_next;
            shift_byte_reg  <= shift_byte_next;
            byte_index_reg  <= byte_index_next;
            crc_reg         <= crc_next;
            held_value_reg  <= held_value_next;
            active_mode_reg <= active_mode_next;
            wait_ticks_reg  <= wait_ticks_next;
        end
    end

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.done_res |-> !res.busy_res)
        else $error("done raised while still busy");

    a_quiet_when_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        !res.done_res |-> (res.outcome == OUTCOME_OK && res.reading == 16'h0000))
        else $error("outcome or reading set without done");

    a_wait_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_WAIT && !item.dat_in) |=> phase_reg == PH_RD_LO)
        else $error("conversion end did not start the read");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= RESET_CLOCKS)
        else $error("bit counter out of range");

endmodule

// File: test/humidity_sensor_two_wire_reader_test.sv
// ----------------------------------------------------------------------------
// humidity_sensor_two_wire_reader_test
// Self-checking bench for the two-wire sensor reader. A behavioral sensor
// answers each transaction tick by tick (acknowledge, conversion wait, data
// and CRC bytes), with missing acknowledges, bad CRCs and wait timeouts mixed
// in. A cycle-accurate model of the sequencer predicts every output beat.
// ----------------------------------------------------------------------------
module humidity_sensor_two_wire_reader_test;
    import hstw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [4:0] {
        P_IDLE, P_WAKE_HI, P_WAKE_LO,
        P_START0, P_START1, P_START2, P_START3, P_START4, P_START5,
        P_CMD_LO, P_CMD_HI, P_ACK_LO, P_ACK_HI, P_CONV,
        P_READ_LO, P_READ_HI, P_RACK_LO, P_RACK_HI
    } seq_phase_e;

    typedef enum int {FAULT_NONE, FAULT_NACK, FAULT_CRC, FAULT_TIMEOUT} fault_e;

    typedef struct packed {
        cfg_t        cfg;
        seq_phase_e  phase;
        logic [15:0] ticks;
        logic [3:0]  bit_no;
        logic [7:0]  shreg;
        logic [1:0]  byte_no;
        logic [7:0]  crc;
        logic [15:0] value;
        logic [2:0]  mode;
        logic [23:0] wait_cnt;
    } reader_state_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [0] start_req, [3:1] mode, [4] dat_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] sck, [1] dat_pull_low, [2] busy_res, [3] done_res,
    // [5:4] outcome, [21:6] reading
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // link_state follows accepted transactions, plan_state follows generated ones
    reader_state_t link_state;
    reader_state_t plan_state;
    item_t         pending_ticks[$];
    result_t       predicted_outputs[$];
    item_t         offer_item;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          ticks_queued = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen;
    int          hold_left;

    // sensor behavior for the transaction being generated
    int          conv_left;
    logic        nack_due;
    logic [7:0]  crc_flip;
    logic [7:0]  data_msb;
    logic [7:0]  data_lsb;
    logic [7:0]  status_byte;

    humidity_sensor_two_wire_reader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] crc31_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int k = 7; k >= 0; k--)
        begin
            fb  = crc[7] ^ data[k];
            crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return crc;
    endfunction

    function automatic logic [7:0] reflect_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
            r[k] = v[7 - k];
        return r;
    endfunction

    function automatic void enter_phase(inout reader_state_t st, input seq_phase_e p);
        st.phase = p;
        st.ticks = '0;
    endfunction

    function automatic void store_reg(inout cfg_t c, input logic [2:0] idx,
                                      input logic [23:0] v);
        case (idx)
            REG_HALF_PERIOD: c.half_period         = v[15:0];
            REG_WAIT_LIMIT:  c.wait_limit          = v;
            REG_TEMP_CMD:    c.temperature_command = v[7:0];
            REG_HUMID_CMD:   c.humidity_command    = v[7:0];
            REG_STATUS_CMD:  c.status_command      = v[7:0];
            REG_SOFT_CMD:    c.soft_reset_command  = v[7:0];
            default: ;
        endcase
    endfunction

    function automatic void reset_state(inout reader_state_t st);
        st                         = '0;
        st.phase                   = P_IDLE;
        st.cfg.half_period         = 16'd50;
        st.cfg.temperature_command = 8'd3;
        st.cfg.humidity_command    = 8'd5;
        st.cfg.status_command      = 8'd7;
        st.cfg.soft_reset_command  = 8'd30;
    endfunction

    // Advance the sequencer by one tick and return the pin and status levels.
    function automatic result_t reader_tick(inout reader_state_t st, input item_t it);
        result_t    r;
        logic [7:0] cmd;
        logic       more;
        r = '0;
        case (st.phase)
            P_IDLE:
                if (it.start_req && it.mode <= MODE_IFACE_RST)
                begin
                    st.mode    = it.mode;
                    st.bit_no  = '0;
                    st.byte_no = '0;
                    st.value   = '0;
                    st.wait_cnt = '0;
                    if (it.mode == MODE_IFACE_RST)
                        enter_phase(st, P_WAKE_HI);
                    else
                    begin
                        case (it.mode)
                            MODE_TEMP:   cmd = st.cfg.temperature_command;
                            MODE_HUMID:  cmd = st.cfg.humidity_command;
                            MODE_STATUS: cmd = st.cfg.status_command;
                            default:     cmd = st.cfg.soft_reset_command;
                        endcase
                        st.shreg = cmd;
                        st.crc   = crc31_byte(8'h00, cmd);
                        enter_phase(st, P_START0);
                    end
                end
            P_CONV:
                if (!it.dat_in)
                begin
                    st.bit_no = '0;
                    enter_phase(st, P_READ_LO);
                end
                else
                begin
                    if (st.wait_cnt != WAIT_MAX)
                        st.wait_cnt = st.wait_cnt + 24'd1;
                    if (st.cfg.wait_limit != '0 && st.wait_cnt >= st.cfg.wait_limit)
                    begin
                        enter_phase(st, P_IDLE);
                        r.done_res = 1'b1;
                        r.outcome  = OUTCOME_TIMEOUT;
                    end
                end
            default:
            begin
                st.ticks = st.ticks + 16'd1;
                if (st.ticks >= st.cfg.half_period)
                begin
                    case (st.phase)
                        P_WAKE_HI: enter_phase(st, P_WAKE_LO);
                        P_WAKE_LO:
                        begin
                            st.bit_no = st.bit_no + 4'd1;
                            if (st.bit_no >= RESET_CLOCKS)
                            begin
                                st.bit_no = '0;
                                enter_phase(st, P_START0);
                            end
                            else
                                enter_phase(st, P_WAKE_HI);
                        end
                        P_START0: enter_phase(st, P_START1);
                        P_START1: enter_phase(st, P_START2);
                        P_START2: enter_phase(st, P_START3);
                        P_START3: enter_phase(st, P_START4);
                        P_START4: enter_phase(st, P_START5);
                        P_START5:
                            if (st.mode == MODE_IFACE_RST)
                            begin
                                enter_phase(st, P_IDLE);
                                r.done_res = 1'b1;
                            end
                            else
                            begin
                                st.bit_no = '0;
                                enter_phase(st, P_CMD_LO);
                            end
                        P_CMD_LO: enter_phase(st, P_CMD_HI);
                        P_CMD_HI:
                        begin
                            st.shreg  = {st.shreg[6:0], 1'b0};
                            st.bit_no = st.bit_no + 4'd1;
                            if (st.bit_no >= 4'd8)
                                enter_phase(st, P_ACK_LO);
                            else
                                enter_phase(st, P_CMD_LO);
                        end
                        P_ACK_LO: enter_phase(st, P_ACK_HI);
                        P_ACK_HI:
                            if (it.dat_in)
                            begin
                                enter_phase(st, P_IDLE);
                                r.done_res = 1'b1;
                                r.outcome  = OUTCOME_NO_ACK;
                            end
                            else if (st.mode == MODE_SOFT_RST)
                            begin
                                enter_phase(st, P_IDLE);
                                r.done_res = 1'b1;
                            end
                            else
                            begin
                                st.wait_cnt = '0;
                                enter_phase(st, P_CONV);
                            end
                        P_READ_LO: enter_phase(st, P_READ_HI);
                        P_READ_HI:
                        begin
                            st.shreg  = {st.shreg[6:0], it.dat_in};
                            st.bit_no = st.bit_no + 4'd1;
                            if (st.bit_no >= 4'd8)
                                enter_phase(st, P_RACK_LO);
                            else
                                enter_phase(st, P_READ_LO);
                        end
                        P_RACK_LO: enter_phase(st, P_RACK_HI);
                        P_RACK_HI:
                        begin
                            st.bit_no = '0;
                            if (st.mode == MODE_STATUS)
                            begin
                                enter_phase(st, P_IDLE);
                                r.done_res = 1'b1;
                                r.reading  = {8'h00, st.shreg};
                            end
                            else if (st.byte_no == 2'd0)
                            begin
                                st.value   = {st.shreg, 8'h00};
                                st.crc     = crc31_byte(st.crc, st.shreg);
                                st.byte_no = 2'd1;
                                enter_phase(st, P_READ_LO);
                            end
                            else if (st.byte_no == 2'd1)
                            begin
                                st.value   = st.value | {8'h00, st.shreg};
                                st.crc     = crc31_byte(st.crc, st.shreg);
                                st.byte_no = 2'd2;
                                enter_phase(st, P_READ_LO);
                            end
                            else
                            begin
                                enter_phase(st, P_IDLE);
                                r.done_res = 1'b1;
                                if (reflect_byte(st.shreg) == st.crc)
                                    r.reading = st.value;
                                else
                                    r.outcome = OUTCOME_CRC_ERR;
                            end
                        end
                        default: enter_phase(st, P_IDLE);
                    endcase
                end
            end
        endcase

        // master acknowledges every data byte except the last one
        more = (st.mode == MODE_TEMP || st.mode == MODE_HUMID) && st.byte_no < 2'd2;
        case (st.phase)
            P_WAKE_HI, P_START0, P_START4, P_ACK_HI, P_READ_HI:
                r.sck = 1'b1;
            P_START1, P_START3:
            begin
                r.sck          = 1'b1;
                r.dat_pull_low = 1'b1;
            end
            P_START2:  r.dat_pull_low = 1'b1;
            P_CMD_LO:  r.dat_pull_low = ~st.shreg[7];
            P_CMD_HI:
            begin
                r.sck          = 1'b1;
                r.dat_pull_low = ~st.shreg[7];
            end
            P_RACK_LO: r.dat_pull_low = more;
            P_RACK_HI:
            begin
                r.sck          = 1'b1;
                r.dat_pull_low = more;
            end
            default: ;
        endcase
        r.busy_res = st.phase != P_IDLE;
        return r;
    endfunction

    // Level the sensor puts on DATA for the next tick of the planned sequence.
    function automatic logic sensor_dat();
        logic       last;
        logic [7:0] byte_out;
        last = int'(plan_state.ticks) + 1 >= int'(plan_state.cfg.half_period);
        case (plan_state.phase)
            P_ACK_HI:
                return last ? nack_due : ($urandom_range(1) == 1);
            P_CONV:
            begin
                if (conv_left > 0)
                begin
                    conv_left--;
                    return 1'b1;
                end
                return 1'b0;
            end
            P_READ_HI:
            begin
                if (!last)
                    return $urandom_range(1) == 1;
                if (plan_state.mode == MODE_STATUS)
                    byte_out = status_byte;
                else if (plan_state.byte_no == 2'd0)
                    byte_out = data_msb;
                else if (plan_state.byte_no == 2'd1)
                    byte_out = data_lsb;
                else
                    byte_out = reflect_byte(plan_state.crc) ^ crc_flip;
                return byte_out[3'd7 - plan_state.bit_no[2:0]];
            end
            default:
                return $urandom_range(1) == 1;
        endcase
    endfunction

    function automatic result_t feed(input logic start, input logic [2:0] mode,
                                     input logic dat);
        item_t it;
        it.start_req = start;
        it.mode      = mode;
        it.dat_in    = dat;
        pending_ticks.push_back(it);
        ticks_queued++;
        return reader_tick(plan_state, it);
    endfunction

    // idle tick: either no request or a request with an undefined mode
    function automatic void idle_noise();
        logic    s;
        s = $urandom_range(1) == 1;
        void'(feed(s, s ? 3'($urandom_range(5, 7)) : 3'($urandom_range(7)),
                   $urandom_range(1) == 1));
    endfunction

    task automatic sensor_transaction(input logic [2:0] mode, input fault_e fault);
        result_t r;
        int      lim;
        lim         = int'(plan_state.cfg.wait_limit);
        nack_due    = fault == FAULT_NACK;
        crc_flip    = fault == FAULT_CRC ? 8'($urandom_range(1, 255)) : 8'h00;
        data_msb    = 8'($urandom_range(255));
        data_lsb    = 8'($urandom_range(255));
        status_byte = 8'($urandom_range(255));
        if (fault == FAULT_TIMEOUT)
            conv_left = lim + $urandom_range(1, 3);
        else if (lim == 0)
            conv_left = $urandom_range(0, 40);
        else
            conv_left = $urandom_range(0, lim > 40 ? 40 : lim - 1);
        repeat ($urandom_range(0, 3))
            idle_noise();
        r = feed(1'b1, mode, $urandom_range(1) == 1);
        // requests while busy must be ignored, including on the done tick
        while (r.busy_res)
            r = feed($urandom_range(1) == 1, 3'($urandom_range(7)), sensor_dat());
    endtask

    task automatic random_batch(input int min_ticks, input int min_trans);
        int         first;
        int         n;
        int         roll;
        int         lim;
        logic [2:0] mode;
        fault_e     fault;
        first = ticks_queued;
        n     = 0;
        lim   = int'(plan_state.cfg.wait_limit);
        while (ticks_queued - first < min_ticks || n < min_trans)
        begin
            mode  = 3'($urandom_range(0, 4));
            roll  = $urandom_range(99);
            fault = FAULT_NONE;
            if (roll < 8 && mode != MODE_IFACE_RST)
                fault = FAULT_NACK;
            else if (roll < 16 && (mode == MODE_TEMP || mode == MODE_HUMID))
                fault = FAULT_CRC;
            else if (roll < 24 && lim != 0 && lim <= 64 && mode <= MODE_STATUS)
                fault = FAULT_TIMEOUT;
            sensor_transaction(mode, fault);
            n++;
        end
    endtask

    // hold off until everything offered has come back
    task automatic settle();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || s_tvalid || predicted_outputs.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [23:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        store_reg(plan_state.cfg, idx, value);
        store_reg(link_state.cfg, idx, value);
    endtask

    task automatic random_commands();
        set_reg(REG_TEMP_CMD, 24'($urandom_range(255)));
        set_reg(REG_HUMID_CMD, 24'($urandom_range(255)));
        set_reg(REG_STATUS_CMD, 24'($urandom_range(255)));
        set_reg(REG_SOFT_CMD, 24'($urandom_range(255)));
    endtask

    function automatic void record_tick(input logic [7:0] data);
        item_t it;
        it.start_req = data[0];
        it.mode      = data[3:1];
        it.dat_in    = data[4];
        predicted_outputs.push_back(reader_tick(link_state, it));
    endfunction

    function automatic void compare_result(input logic [23:0] got);
        result_t want;
        result_t seen;
        seen.sck          = got[0];
        seen.dat_pull_low = got[1];
        seen.busy_res     = got[2];
        seen.done_res     = got[3];
        seen.outcome      = got[5:4];
        seen.reading      = got[21:6];
        if (predicted_outputs.size() == 0)
        begin
            if (mismatches < 10)
                $display("cycle %0d: output beat %h with nothing predicted", cycle_count, got);
            mismatches++;
            return;
        end
        want = predicted_outputs.pop_front();
        if (seen.sck !== want.sck || seen.dat_pull_low !== want.dat_pull_low ||
            seen.busy_res !== want.busy_res || seen.done_res !== want.done_res ||
            seen.outcome !== want.outcome || seen.reading !== want.reading)
        begin
            if (mismatches < 10)
            begin
                $display("cycle %0d: expected sck=%b pull=%b busy=%b done=%b outcome=%0d reading=%h",
                         cycle_count, want.sck, want.dat_pull_low, want.busy_res,
                         want.done_res, want.outcome, want.reading);
                $display("cycle %0d: actual   sck=%b pull=%b busy=%b done=%b outcome=%0d reading=%h",
                         cycle_count, seen.sck, seen.dat_pull_low, seen.busy_res,
                         seen.done_res, seen.outcome, seen.reading);
            end
            mismatches++;
        end
    endfunction

    // driver: predict on each accepted transaction, then refill the slot
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                record_tick(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offer_item = pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, offer_item.dat_in, offer_item.mode,
                                 offer_item.start_req};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, armed by a toggle from the stimulus
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                compare_result(m_tdata);
            m_tready <= hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        reset_state(link_state);
        reset_state(plan_state);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 47;

        // short phases; the command bytes keep their power-on values here
        set_reg(REG_HALF_PERIOD, 24'd1);
        set_reg(REG_WAIT_LIMIT, 24'd6);

        // undefined modes are dropped while idle
        void'(feed(1'b1, 3'd5, 1'b0));
        void'(feed(1'b1, 3'd6, 1'b1));
        void'(feed(1'b1, 3'd7, 1'b0));
        void'(feed(1'b0, 3'd0, 1'b1));
        sensor_transaction(MODE_SOFT_RST, FAULT_NONE);
        sensor_transaction(MODE_TEMP, FAULT_NONE);
        sensor_transaction(MODE_STATUS, FAULT_TIMEOUT);
        settle();

        set_reg(REG_TEMP_CMD, 24'h00);
        set_reg(REG_HUMID_CMD, 24'hFF);
        set_reg(REG_STATUS_CMD, 24'hA5);
        set_reg(REG_SOFT_CMD, 24'h5A);
        sensor_transaction(MODE_STATUS, FAULT_NONE);
        sensor_transaction(MODE_IFACE_RST, FAULT_NONE);
        sensor_transaction(MODE_TEMP, FAULT_NACK);
        sensor_transaction(MODE_HUMID, FAULT_CRC);
        sensor_transaction(MODE_TEMP, FAULT_TIMEOUT);
        sensor_transaction(MODE_SOFT_RST, FAULT_NACK);
        settle();

        // zero half period behaves as one tick per phase; wait without limit
        set_reg(REG_HALF_PERIOD, 24'd0);
        set_reg(REG_WAIT_LIMIT, 24'd0);
        random_commands();
        random_batch(60, 1);
        settle();

        send_idle_pct = 47;
        recv_idle_pct = 35;
        set_reg(REG_HALF_PERIOD, 24'd2);
        set_reg(REG_WAIT_LIMIT, 24'($urandom_range(1, 30)));
        random_commands();
        hold_toggle = ~hold_toggle;
        random_batch(100, 1);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_reg(REG_HALF_PERIOD, 24'd1);
        set_reg(REG_WAIT_LIMIT, 24'hFF_FFFF);
        set_reg(REG_STATUS_CMD, 24'hFF);
        sensor_transaction(MODE_IFACE_RST, FAULT_NONE);
        sensor_transaction(MODE_STATUS, FAULT_NONE);
        settle();

        set_reg(REG_HALF_PERIOD, 24'hFFFF);
        repeat (20) idle_noise();
        settle();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && predicted_outputs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
